// ===== design/caga_pkg.sv =====
package caga_pkg;

    localparam int unsigned DefGridWidth  = 64;
    localparam int unsigned DefGridHeight = 64;

    typedef enum logic [1:0] {
        OP_INCR  = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] col;
        logic [7:0] row;
    } in_item_t;

    typedef struct packed {
        logic [1:0] cell_value;
        logic       status;
    } out_item_t;

    // Datapath commands issued by the controller.
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_ACCESS,
        CMD_INCR_WRITE,
        CMD_TICK_STEP,
        CMD_CLEAR_STEP,
        CMD_SWAP
    } cmd_t;

    typedef struct packed {
        logic tick_done;
        logic clear_done;
    } dp_status_t;

    // Next cell value from the current value and the neighbor sum.
    function automatic logic [1:0] rule_next(input logic [1:0] v, input logic [4:0] s);
        logic [1:0] r;
        begin
            r = v;
            if (s < 5'd3 || s >= 5'd12)
            begin
                r = (v != 2'd0) ? v - 2'd1 : 2'd0;
            end
            else if (s >= 5'd6 && s < 5'd9)
            begin
                r = (v != 2'd3) ? v + 2'd1 : 2'd3;
            end
            return r;
        end
    endfunction

endpackage

// ===== design/caga_datapath.sv =====
module caga_datapath
    import caga_pkg::*;
#(
    parameter int unsigned GRID_WIDTH  = DefGridWidth,
    parameter int unsigned GRID_HEIGHT = DefGridHeight
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  in_item_t   item,
    output dp_status_t dp_status,
    output out_item_t  result
);

    localparam int unsigned CellCount = GRID_WIDTH * GRID_HEIGHT;
    localparam int unsigned AddrW     = $clog2(CellCount);
    localparam int unsigned RowBufLen = 2 * GRID_WIDTH + 3;

    // Two grid buffers; bank_reg selects the one holding the current grid.
    logic [1:0] mem0 [CellCount];
    logic [1:0] mem1 [CellCount];
    logic       bank_reg;
    logic       bank_next;

    // Read-ahead scan position (cell entering the window) and write position.
    logic [7:0]  rc_reg, rr_reg, rc_next, rr_next;
    logic [7:0]  wc_reg, wr_reg, wc_next, wr_next;
    logic [AddrW-1:0] raddr_reg, raddr_next;
    logic [AddrW-1:0] waddr_reg, waddr_next;
    logic        rvalid_reg, rvalid_next;
    logic [1:0]  rd0_reg, rd1_reg;

    // Line buffer of the last two rows plus three cells.
    logic [1:0] line_reg [RowBufLen];

    logic        in_range;
    logic [AddrW-1:0] item_addr;
    logic [1:0]  cur_rd;
    logic [1:0]  win [9];
    logic [4:0]  nsum;
    logic [1:0]  newv;
    logic        scan_active;

    assign in_range  = (32'(item.col) < GRID_WIDTH) && (32'(item.row) < GRID_HEIGHT);
    assign item_addr = AddrW'(32'(item.row) * GRID_WIDTH + 32'(item.col));
    assign cur_rd    = bank_reg ? rd1_reg : rd0_reg;
    assign scan_active = (cmd == CMD_TICK_STEP);

    // Synchronous reads from both banks.
    always_ff @(posedge clk)
    begin
        rd0_reg <= mem0[scan_active ? raddr_reg : item_addr];
        rd1_reg <= mem1[scan_active ? raddr_reg : item_addr];
    end

    // Window taps: center cell sits GRID_WIDTH+1 behind the newest cell.
    always_comb
    begin
        win[0] = line_reg[0];
        win[1] = line_reg[1];
        win[2] = line_reg[2];
        win[3] = line_reg[GRID_WIDTH];
        win[4] = line_reg[GRID_WIDTH+1];
        win[5] = line_reg[GRID_WIDTH+2];
        win[6] = line_reg[2*GRID_WIDTH];
        win[7] = line_reg[2*GRID_WIDTH+1];
        win[8] = line_reg[2*GRID_WIDTH+2];
        // Mask neighbors that fall outside the grid at the write position.
        if (wc_reg == 8'd0)
        begin
            win[2] = 2'd0; win[5] = 2'd0; win[8] = 2'd0;
        end
        if (32'(wc_reg) == GRID_WIDTH - 1)
        begin
            win[0] = 2'd0; win[3] = 2'd0; win[6] = 2'd0;
        end
        if (wr_reg == 8'd0)
        begin
            win[6] = 2'd0; win[7] = 2'd0; win[8] = 2'd0;
        end
        if (32'(wr_reg) == GRID_HEIGHT - 1)
        begin
            win[0] = 2'd0; win[1] = 2'd0; win[2] = 2'd0;
        end
        nsum = 5'(win[0]) + 5'(win[1]) + 5'(win[2]) + 5'(win[3])
             + 5'(win[5]) + 5'(win[6]) + 5'(win[7]) + 5'(win[8]);
        newv = rule_next(win[4], nsum);
    end

    // The write position trails the read-ahead by GRID_WIDTH+1 cells plus latency.
    logic [AddrW:0] lag_reg, lag_next;
    localparam int unsigned Lag = GRID_WIDTH + 3;
    logic write_en;
    assign write_en = scan_active && (32'(lag_reg) == Lag);

    always_comb
    begin
        bank_next   = bank_reg;
        rc_next     = rc_reg;
        rr_next     = rr_reg;
        raddr_next  = raddr_reg;
        rvalid_next = rvalid_reg;
        wc_next     = wc_reg;
        wr_next     = wr_reg;
        waddr_next  = waddr_reg;
        lag_next    = lag_reg;
        case (cmd)
            CMD_TICK_STEP:
            begin
                // Advance the read-ahead position.
                if (rvalid_reg)
                begin
                    raddr_next = raddr_reg + AddrW'(1);
                    if (32'(rc_reg) == GRID_WIDTH - 1)
                    begin
                        rc_next = 8'd0;
                        if (32'(rr_reg) == GRID_HEIGHT - 1)
                        begin
                            rvalid_next = 1'b0;
                        end
                        else
                        begin
                            rr_next = rr_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        rc_next = rc_reg + 8'd1;
                    end
                end
                if (write_en)
                begin
                    waddr_next = waddr_reg + AddrW'(1);
                    if (32'(wc_reg) == GRID_WIDTH - 1)
                    begin
                        wc_next = 8'd0;
                        wr_next = wr_reg + 8'd1;
                    end
                    else
                    begin
                        wc_next = wc_reg + 8'd1;
                    end
                end
                else
                begin
                    lag_next = lag_reg + (AddrW+1)'(1);
                end
            end
            CMD_SWAP:
            begin
                bank_next = !bank_reg;
            end
            default:
            begin
                rc_next = 8'd0; rr_next = 8'd0; raddr_next = '0; rvalid_next = 1'b1;
                wc_next = 8'd0; wr_next = 8'd0; waddr_next = '0; lag_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg   <= 1'b0;
            rc_reg     <= 8'd0;
            rr_reg     <= 8'd0;
            raddr_reg  <= '0;
            rvalid_reg <= 1'b1;
            wc_reg     <= 8'd0;
            wr_reg     <= 8'd0;
            waddr_reg  <= '0;
            lag_reg    <= '0;
        end
        else
        begin
            bank_reg   <= bank_next;
            rc_reg     <= rc_next;
            rr_reg     <= rr_next;
            raddr_reg  <= raddr_next;
            rvalid_reg <= rvalid_next;
            wc_reg     <= wc_next;
            wr_reg     <= wr_next;
            waddr_reg  <= waddr_next;
            lag_reg    <= lag_next;
        end
    end

    // Line buffer shift; the read data of the previous cycle enters at the tail.
    logic rvalid_d_reg;
    always_ff @(posedge clk)
    begin
        rvalid_d_reg <= rvalid_reg && scan_active;
        if (scan_active)
        begin
            line_reg[0] <= rvalid_d_reg ? cur_rd : 2'd0;
            for (int i = 1; i < RowBufLen; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    // Clear sweep address counter.
    logic [AddrW-1:0] clr_reg;

    // Memory writes: increment, tick result, clear sweep.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_INCR_WRITE:
            begin
                if (in_range)
                begin
                    if (bank_reg) mem1[item_addr] <= cur_rd + 2'd1;
                    else          mem0[item_addr] <= cur_rd + 2'd1;
                end
            end
            CMD_TICK_STEP:
            begin
                if (write_en)
                begin
                    if (bank_reg) mem0[waddr_reg] <= newv;
                    else          mem1[waddr_reg] <= newv;
                end
            end
            CMD_CLEAR_STEP:
            begin
                mem0[clr_reg] <= 2'd0;
                mem1[clr_reg] <= 2'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd == CMD_CLEAR_STEP)
        begin
            clr_reg <= clr_reg + AddrW'(1);
        end
        else
        begin
            clr_reg <= '0;
        end
    end

    assign dp_status.tick_done  = write_en && (32'(waddr_reg) == CellCount - 1);
    assign dp_status.clear_done = (32'(clr_reg) == CellCount - 1);

    // Result of the item in flight.
    always_comb
    begin
        result.cell_value = 2'd0;
        result.status     = 1'b0;
        if (item.opcode == OP_INCR || item.opcode == OP_READ)
        begin
            result.status = !in_range;
            if (in_range)
            begin
                result.cell_value = (item.opcode == OP_INCR) ? cur_rd + 2'd1 : cur_rd;
            end
        end
    end

endmodule

// ===== design/caga_ctrl.sv =====
module caga_ctrl
    import caga_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_opcode,
    input  logic [1:0] opcode,
    input  logic       out_stall,
    input  dp_status_t dp_status,
    output logic       in_stall,
    output logic       out_valid,
    output logic       capture,
    output logic       result_load,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACCESS,
        ST_RESULT,
        ST_TICK,
        ST_SWAP,
        ST_CLEAR,
        ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    assign in_stall    = (state_reg != ST_IDLE) || ovalid_reg;
    assign capture     = in_valid && !in_stall;
    assign out_valid   = ovalid_reg;
    assign result_load = (state_reg == ST_RESULT);

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd         = CMD_IDLE;
        case (state_reg)
            ST_INIT:
            begin
                // Zero the grid after reset; no result is produced.
                cmd = CMD_CLEAR_STEP;
                if (dp_status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (capture)
                begin
                    case (in_opcode)
                        OP_TICK:  state_next = ST_TICK;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_ACCESS;
                    endcase
                end
            end
            ST_ACCESS:
            begin
                cmd        = CMD_ACCESS;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                cmd         = (opcode == OP_INCR) ? CMD_INCR_WRITE : CMD_IDLE;
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_TICK:
            begin
                cmd = CMD_TICK_STEP;
                if (dp_status.tick_done)
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                cmd        = CMD_SWAP;
                state_next = ST_RESULT;
            end
            ST_CLEAR:
            begin
                cmd = CMD_CLEAR_STEP;
                if (dp_status.clear_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== design/four_level_cellular_automaton_grid_core.sv =====
// Channel | Direction | Payload    | Handshake
// in      | input     | in_item_t  | in_valid / in_stall
// out     | output    | out_item_t | out_valid / out_stall
//
// Increment and read pass through the access and result states before out_valid rises.
// A tick streams the grid through a two-row line buffer, one cell per cycle; out_valid
// rises once the last cell is written and the banks are swapped.
// A clear sweeps both buffers one cell per cycle.
// After reset the same sweep zeroes the grid while the input is stalled.
// One transaction is in flight; input stalls until the result is taken.
module four_level_cellular_automaton_grid_core
    import caga_pkg::*;
#(
    parameter int unsigned GRID_WIDTH  = DefGridWidth,
    parameter int unsigned GRID_HEIGHT = DefGridHeight
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    in_item_t   item_reg;
    out_item_t  res_reg;
    out_item_t  res_comb;
    dp_status_t dp_status;
    cmd_t       cmd;
    logic       capture;
    logic       result_load;

    caga_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_opcode   (in_data.opcode),
        .opcode      (item_reg.opcode),
        .out_stall   (out_stall),
        .dp_status   (dp_status),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .capture     (capture),
        .result_load (result_load),
        .cmd         (cmd)
    );

    caga_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item_reg),
        .dp_status (dp_status),
        .result    (res_comb)
    );

    // Capture the transaction and hold its result.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            item_reg <= in_data;
        end
        if (result_load)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_data = res_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input accepted while result pending");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> out_valid) else $error("result not presented");
    a_status_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status) |-> (out_data.cell_value == 2'd0))
        else $error("out of range with nonzero value");
`endif

endmodule
